### rtl/core/fsd_pkg.sv
// Shared types, constants and arithmetic steps for the motion fire seed block.
package fsd_pkg;

    localparam int unsigned ChanW     = 8;
    localparam int unsigned RgbW      = 3 * ChanW;
    localparam int unsigned RandW     = 16;
    localparam int unsigned CfgW      = 9;
    localparam int unsigned CfgAddrW  = 3;
    localparam int unsigned SqW       = 2 * ChanW;
    localparam int unsigned SumW      = SqW + 2;
    localparam int unsigned GrayW     = ChanW + 5;
    localparam int unsigned RecipW    = 18;
    localparam int unsigned RecipShift = 19;
    localparam int unsigned ProdW     = SumW + RecipW;
    localparam int unsigned NumStages = 4;
    localparam int unsigned RemSteps  = RandW / NumStages;

    // ceil(2^19 / 3): exact floor divide by three for sums below 2^19
    localparam logic [RecipW-1:0] RecipDiv3 = 18'd174763;
    localparam logic [CfgW-1:0]   SpanMax   = 9'd256;

    // Register indexes on the configuration port
    typedef enum logic [CfgAddrW-1:0] {
        REG_HARD_MODE   = 3'd0,
        REG_MOTION_THR  = 3'd1,
        REG_LUMA_THR    = 3'd2,
        REG_ALPHA_VAR   = 3'd3,
        REG_COLOR_COUNT = 3'd4
    } t_cfg_reg;

    // Live configuration, spans already saturated into 1..256
    typedef struct packed {
        logic            hard_mode;
        logic [CfgW-1:0] motion_thr;
        logic [CfgW-1:0] luma_thr;
        logic [CfgW-1:0] alpha_span;
        logic [CfgW-1:0] color_span;
    } t_cfg;

    // Partial state of the digit-by-digit square root
    typedef struct packed {
        logic [CfgW-1:0]  rem;
        logic [ChanW-1:0] root;
    } t_sqrt_st;

    // Saturate a span register into 1..256
    function automatic logic [CfgW-1:0] span_clamp(logic [CfgW-1:0] v);
        logic [CfgW-1:0] res;
        if (v == '0) begin
            res = 9'd1;
        end else if (v > SpanMax) begin
            res = SpanMax;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // One restoring remainder step: bring in one dividend bit
    function automatic logic [CfgW-1:0] rem_step(logic [CfgW-1:0] rem, logic din,
                                                 logic [CfgW-1:0] div);
        logic [CfgW:0] t;
        t = {rem, din};
        if (t >= {1'b0, div}) begin
            t = t - {1'b0, div};
        end
        return t[CfgW-1:0];
    endfunction

    // One square root step: bring in two radicand bits, settle one root bit
    function automatic t_sqrt_st sqrt_step(t_sqrt_st st, logic [1:0] pair);
        logic [CfgW+1:0] r;
        logic [CfgW+1:0] trial;
        t_sqrt_st        res;
        r     = {st.rem, pair};
        trial = {1'b0, st.root, 2'b01};
        if (r >= trial) begin
            r        = r - trial;
            res.root = {st.root[ChanW-2:0], 1'b1};
        end else begin
            res.root = {st.root[ChanW-2:0], 1'b0};
        end
        res.rem = r[CfgW-1:0];
        return res;
    endfunction

endpackage

### rtl/core/motion_diff_fire_seed.sv
// Top level of the motion fire seed block: handshake control and result stage.
//
// Usage: one input word carries a previous-frame pixel, the co-located current pixel
// and two random words; one output word carries the fire-seed alpha and palette index.
// Both channels use valid/ready; a word moves when valid and ready are high together.
// Path: an accepted word passes four arithmetic stages (squared distance, divide
// by three, two halves of an eight-step square root, run alongside two remainder
// units), then the output register that drives o_valid.
// Throughput: one word per clock; the input is taken while results wait downstream,
// and each stage holds its word only while the stage after it is full and stalled.
// A stalled receiver therefore backs the pipe up one stage at a time; o_ready drops
// only once all five stages are full. Nothing is lost or repeated.
// Reset (i_rst_n low at a clock edge) empties the pipe and loads the register
// defaults: hard mode on, thresholds 15, alpha variation 127, color count 8.
// Configuration: write i_cfg_data to register i_cfg_addr with i_cfg_we; write only
// while the pipe is empty, since stages read the live registers.
module motion_diff_fire_seed (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fsd_pkg::RgbW-1:0]      i_prev_rgb,
    input  logic [fsd_pkg::RgbW-1:0]      i_cur_rgb,
    input  logic [fsd_pkg::RandW-1:0]     i_rand_alpha,
    input  logic [fsd_pkg::RandW-1:0]     i_rand_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fsd_pkg::ChanW-1:0]     o_seed_alpha,
    output logic [fsd_pkg::ChanW-1:0]     o_seed_index,
    input  logic                          i_cfg_we,
    input  logic [fsd_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [fsd_pkg::CfgW-1:0]      i_cfg_data
);

    fsd_pkg::t_cfg                  cfg;
    logic [fsd_pkg::NumStages:0]    en;
    logic [fsd_pkg::NumStages-1:0]  r_v;
    logic                           r_out_v;
    logic [fsd_pkg::ChanW-1:0]      level;
    logic                           luma_low;
    logic [fsd_pkg::CfgW-1:0]       rem_alpha;
    logic [fsd_pkg::CfgW-1:0]       rem_index;
    logic [fsd_pkg::CfgW-1:0]       n_alpha;
    logic [fsd_pkg::CfgW-1:0]       n_index;
    logic [fsd_pkg::ChanW-1:0]      r_seed_alpha;
    logic [fsd_pkg::ChanW-1:0]      r_seed_index;

    fsd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    fsd_motion_pipe u_motion (
        .i_clk      (i_clk),
        .i_en       (en[fsd_pkg::NumStages-1:0]),
        .i_prev_rgb (i_prev_rgb),
        .i_cur_rgb  (i_cur_rgb),
        .i_luma_thr (cfg.luma_thr),
        .o_level    (level),
        .o_luma_low (luma_low)
    );

    fsd_rem_pipe u_rem_alpha (
        .i_clk  (i_clk),
        .i_en   (en[fsd_pkg::NumStages-1:0]),
        .i_word (i_rand_alpha),
        .i_div  (cfg.alpha_span),
        .o_rem  (rem_alpha)
    );

    fsd_rem_pipe u_rem_index (
        .i_clk  (i_clk),
        .i_en   (en[fsd_pkg::NumStages-1:0]),
        .i_word (i_rand_index),
        .i_div  (cfg.color_span),
        .o_rem  (rem_index)
    );

    // Stage loads: a stage moves when empty or when the next one moves
    always_comb begin
        en[fsd_pkg::NumStages] = !r_out_v || i_ready;
        for (int k = fsd_pkg::NumStages - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_ready = en[0];

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < fsd_pkg::NumStages; k++) begin
                if (en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (en[fsd_pkg::NumStages]) begin
                r_out_v <= r_v[fsd_pkg::NumStages-1];
            end
        end
    end

    // Result: alpha choice, luma gate, palette index
    always_comb begin
        if ({1'b0, level} < cfg.motion_thr) begin
            n_alpha = '0;
        end else if (cfg.hard_mode) begin
            n_alpha = (fsd_pkg::SpanMax - cfg.alpha_span) + rem_alpha;
        end else begin
            n_alpha = {1'b0, level};
        end
        if (luma_low) begin
            n_alpha = '0;
        end
        n_index = (fsd_pkg::SpanMax - cfg.color_span) + rem_index;
    end

    always_ff @(posedge i_clk) begin
        if (en[fsd_pkg::NumStages]) begin
            r_seed_alpha <= n_alpha[fsd_pkg::ChanW-1:0];
            r_seed_index <= n_index[fsd_pkg::ChanW-1:0];
        end
    end

    assign o_valid      = r_out_v;
    assign o_seed_alpha = r_seed_alpha;
    assign o_seed_index = r_seed_index;

`ifndef SYNTHESIS
    // An empty output stage never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output stage");

    // An accepted word enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("accepted word missing from first stage");

    // Palette index stays inside the color span
    a_index_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_seed_index} >= (fsd_pkg::SpanMax - cfg.color_span)))
        else $error("palette index below color span");

    // Hard-mode alpha is zero or inside the variation span
    a_alpha_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && cfg.hard_mode && (o_seed_alpha != '0))
            |-> ({1'b0, o_seed_alpha} >= (fsd_pkg::SpanMax - cfg.alpha_span)))
        else $error("hard-mode alpha below variation span");
`endif

endmodule

### rtl/core/fsd_cfg_regs.sv
// Configuration registers with span saturation.
module fsd_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fsd_pkg::CfgAddrW-1:0]  i_cfg_addr,
    input  logic [fsd_pkg::CfgW-1:0]      i_cfg_data,
    output fsd_pkg::t_cfg                 o_cfg
);

    logic                     r_hard_mode;
    logic [fsd_pkg::CfgW-1:0] r_motion_thr;
    logic [fsd_pkg::CfgW-1:0] r_luma_thr;
    logic [fsd_pkg::CfgW-1:0] r_alpha_var;
    logic [fsd_pkg::CfgW-1:0] r_color_count;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hard_mode   <= 1'b1;
            r_motion_thr  <= 9'd15;
            r_luma_thr    <= 9'd15;
            r_alpha_var   <= 9'd127;
            r_color_count <= 9'd8;
        end else if (i_cfg_we) begin
            case (fsd_pkg::t_cfg_reg'(i_cfg_addr))
                fsd_pkg::REG_HARD_MODE:   r_hard_mode   <= i_cfg_data[0];
                fsd_pkg::REG_MOTION_THR:  r_motion_thr  <= i_cfg_data;
                fsd_pkg::REG_LUMA_THR:    r_luma_thr    <= i_cfg_data;
                fsd_pkg::REG_ALPHA_VAR:   r_alpha_var   <= i_cfg_data;
                fsd_pkg::REG_COLOR_COUNT: r_color_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.hard_mode  = r_hard_mode;
        o_cfg.motion_thr = r_motion_thr;
        o_cfg.luma_thr   = r_luma_thr;
        o_cfg.alpha_span = fsd_pkg::span_clamp(r_alpha_var);
        o_cfg.color_span = fsd_pkg::span_clamp(r_color_count);
    end

endmodule

### rtl/core/fsd_motion_pipe.sv
// Motion level pipeline: squared distance, divide by three, square root; luma check.
module fsd_motion_pipe (
    input  logic                              i_clk,
    input  logic [fsd_pkg::NumStages-1:0]     i_en,
    input  logic [fsd_pkg::RgbW-1:0]          i_prev_rgb,
    input  logic [fsd_pkg::RgbW-1:0]          i_cur_rgb,
    input  logic [fsd_pkg::CfgW-1:0]          i_luma_thr,
    output logic [fsd_pkg::ChanW-1:0]         o_level,
    output logic                              o_luma_low
);

    logic [fsd_pkg::SumW-1:0]    n_sum;
    logic                        n_luma_low;
    logic [fsd_pkg::ProdW-1:0]   n_prod;
    fsd_pkg::t_sqrt_st           n_st2;
    fsd_pkg::t_sqrt_st           n_st3;

    logic [fsd_pkg::SumW-1:0]    r_sum;
    logic [fsd_pkg::SqW-1:0]     r_q;
    fsd_pkg::t_sqrt_st           r_st2;
    logic [fsd_pkg::ChanW-1:0]   r_qlo2;
    logic [fsd_pkg::ChanW-1:0]   r_level;
    logic [fsd_pkg::NumStages-1:0] r_luma_low;

    // Stage 0: squared channel distances and gray of the current pixel
    always_comb begin
        logic [fsd_pkg::ChanW-1:0] p;
        logic [fsd_pkg::ChanW-1:0] c;
        logic [fsd_pkg::ChanW-1:0] d;
        logic [fsd_pkg::SqW-1:0]   sq;
        logic [fsd_pkg::GrayW-1:0] gray;
        n_sum = '0;
        for (int k = 0; k < 3; k++) begin
            p = i_prev_rgb[k*fsd_pkg::ChanW +: fsd_pkg::ChanW];
            c = i_cur_rgb[k*fsd_pkg::ChanW +: fsd_pkg::ChanW];
            d = (p >= c) ? (p - c) : (c - p);
            sq = d * d;
            n_sum = n_sum + fsd_pkg::SumW'(sq);
        end
        gray = 13'd11 * fsd_pkg::GrayW'(i_cur_rgb[23:16])
             + 13'd16 * fsd_pkg::GrayW'(i_cur_rgb[15:8])
             + 13'd5  * fsd_pkg::GrayW'(i_cur_rgb[7:0]);
        n_luma_low = {1'b0, gray[fsd_pkg::GrayW-1:5]} < i_luma_thr;
    end

    // Stage 1: divide by three through the reciprocal
    assign n_prod = fsd_pkg::ProdW'(r_sum) * fsd_pkg::ProdW'(fsd_pkg::RecipDiv3);

    // Stage 2: upper four root bits
    always_comb begin
        n_st2 = '0;
        for (int k = 0; k < 4; k++) begin
            n_st2 = fsd_pkg::sqrt_step(n_st2, r_q[fsd_pkg::SqW-1-2*k -: 2]);
        end
    end

    // Stage 3: lower four root bits
    always_comb begin
        n_st3 = r_st2;
        for (int k = 0; k < 4; k++) begin
            n_st3 = fsd_pkg::sqrt_step(n_st3, r_qlo2[fsd_pkg::ChanW-1-2*k -: 2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_sum         <= n_sum;
            r_luma_low[0] <= n_luma_low;
        end
        if (i_en[1]) begin
            r_q           <= n_prod[fsd_pkg::RecipShift +: fsd_pkg::SqW];
            r_luma_low[1] <= r_luma_low[0];
        end
        if (i_en[2]) begin
            r_st2         <= n_st2;
            r_qlo2        <= r_q[fsd_pkg::ChanW-1:0];
            r_luma_low[2] <= r_luma_low[1];
        end
        if (i_en[3]) begin
            r_level       <= n_st3.root;
            r_luma_low[3] <= r_luma_low[2];
        end
    end

    assign o_level    = r_level;
    assign o_luma_low = r_luma_low[fsd_pkg::NumStages-1];

endmodule

### rtl/core/fsd_rem_pipe.sv
// Pipelined restoring remainder of a random word by a span, four bits a stage.
module fsd_rem_pipe (
    input  logic                           i_clk,
    input  logic [fsd_pkg::NumStages-1:0]  i_en,
    input  logic [fsd_pkg::RandW-1:0]      i_word,
    input  logic [fsd_pkg::CfgW-1:0]       i_div,
    output logic [fsd_pkg::CfgW-1:0]       o_rem
);

    logic [fsd_pkg::CfgW-1:0]  r_rem  [fsd_pkg::NumStages];
    logic [fsd_pkg::RandW-1:0] r_word [fsd_pkg::NumStages];

    for (genvar s = 0; s < fsd_pkg::NumStages; s++) begin : g_stage
        logic [fsd_pkg::CfgW-1:0]  in_rem;
        logic [fsd_pkg::RandW-1:0] in_word;
        logic [fsd_pkg::CfgW-1:0]  n_rem;

        if (s == 0) begin : g_first
            assign in_rem  = '0;
            assign in_word = i_word;
        end else begin : g_next
            assign in_rem  = r_rem[s-1];
            assign in_word = r_word[s-1];
        end

        // Bring in this stage's slice of dividend bits, MSB first
        always_comb begin
            n_rem = in_rem;
            for (int k = 0; k < fsd_pkg::RemSteps; k++) begin
                n_rem = fsd_pkg::rem_step(n_rem,
                    in_word[fsd_pkg::RandW-1-s*fsd_pkg::RemSteps-k], i_div);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s]  <= n_rem;
                r_word[s] <= in_word;
            end
        end
    end

    assign o_rem = r_rem[fsd_pkg::NumStages-1];

endmodule
